/* sv/pts_pkg.sv */
// Package for the priority thread scheduler: sizes, codes and shared types.
`timescale 1ns / 1ps

package pts_pkg;

	localparam int THREADS    = 8;
	localparam int SEMAPHORES = 8;

	localparam int THR_W  = $clog2(THREADS);
	localparam int SEM_AW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
	localparam int MARK_W = $clog2(SEMAPHORES + 1);

	localparam int PRIO_W      = 8;
	localparam int PRIO_BITS   = 64;
	localparam int SLEEP_W     = 32;
	localparam int SEMV_W      = 16;
	localparam int KIND_W      = 3;
	localparam int SEMID_W     = 3;
	localparam int IN_DATA_W   = 56;
	localparam int OUT_DATA_W  = 32;

	localparam logic [PRIO_W-1:0] LOWEST_PRIO = 8'd255;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK    = 3'd0,
		KIND_SUSPEND = 3'd1,
		KIND_SLEEP   = 3'd2,
		KIND_WAIT    = 3'd3,
		KIND_SIGNAL  = 3'd4,
		KIND_INIT    = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SEM,
		ST_WAKE,
		ST_PICK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [SEMID_W-1:0]       sem_id;
		logic [SLEEP_W-1:0]       sleep_time;
		logic signed [SEMV_W-1:0] init_value;
	} evt_t;

	typedef struct packed {
		logic [2:0]               running_thread;
		logic                     switched;
		logic                     none_ready;
		logic                     caller_blocked;
		logic                     woke_valid;
		logic [2:0]               woken_thread;
		logic signed [SEMV_W-1:0] sem_value;
	} res_t;

endpackage

/* sv/pts_core.sv */
// Scheduler state and sequencer, with one thread-entry evaluation unit shared by all walks.
`timescale 1ns / 1ps

module pts_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pts_pkg::PRIO_BITS-1:0]    cfg_wdata,
	input  logic                             start,
	input  pts_pkg::evt_t                    ev_in,
	output logic                             idle,
	output logic                             res_valid,
	input  logic                             res_ready,
	output pts_pkg::res_t                    res
);

	localparam int TW = pts_pkg::THREADS;
	localparam int MW = pts_pkg::MARK_W;
	localparam int AW = pts_pkg::THR_W;

	pts_pkg::state_t st_q, st_d;
	pts_pkg::evt_t   ev_q;

	logic [AW-1:0] cur_q, old_q, t_q, cnt_q, pick_q, woken_q;
	logic [pts_pkg::PRIO_W-1:0]    best_q;
	logic                          found_q, none_q, blocked_q, woke_q;
	logic signed [pts_pkg::SEMV_W-1:0] sval_q;
	logic [pts_pkg::PRIO_BITS-1:0] prio_q;

	logic [pts_pkg::SLEEP_W-1:0]       sleep_q [TW];
	logic [MW-1:0]                     mark_q  [TW];
	logic signed [pts_pkg::SEMV_W-1:0] sem_q   [pts_pkg::SEMAPHORES];

	// Shared evaluation unit: looks at the thread entry under the walk pointer.
	logic [pts_pkg::SLEEP_W-1:0] ent_sleep;
	logic [MW-1:0]               ent_mark;
	logic [pts_pkg::PRIO_W-1:0]  ent_prio;
	logic                        ent_ready, ent_match, last_step;
	logic [MW-1:0]               sem_mark;
	logic [AW-1:0]               t_next, cur_next;

	// Semaphore arithmetic.
	logic [pts_pkg::SEM_AW-1:0]        sidx;
	logic signed [pts_pkg::SEMV_W-1:0] sem_cur, sem_sat;
	logic signed [pts_pkg::SEMV_W:0]   sem_sum;
	logic                              in_sem_ok;

	assign ent_sleep = sleep_q[t_q];
	assign ent_mark  = mark_q[t_q];
	assign ent_prio  = prio_q[{t_q, 3'b000} +: pts_pkg::PRIO_W];
	assign ent_ready = (ent_mark == '0) && (ent_sleep == '0) && (ent_prio < best_q);
	assign sem_mark  = MW'({1'b0, ev_q.sem_id} + 4'd1);
	assign ent_match = (ent_mark == sem_mark);
	assign last_step = (cnt_q == AW'(TW - 1));
	assign t_next    = (t_q == AW'(TW - 1)) ? '0 : t_q + 1'b1;
	assign cur_next  = (cur_q == AW'(TW - 1)) ? '0 : cur_q + 1'b1;

	assign sidx    = pts_pkg::SEM_AW'(ev_q.sem_id);
	assign sem_cur = sem_q[sidx];
	assign sem_sum = {sem_cur[pts_pkg::SEMV_W-1], sem_cur} +
		((ev_q.kind == pts_pkg::KIND_WAIT) ? 17'h1FFFF : 17'h00001);
	assign in_sem_ok = (32'(ev_in.sem_id) < pts_pkg::SEMAPHORES);

	always_comb begin
		if (sem_sum > 17'sd32767) begin
			sem_sat = 16'sd32767;
		end else if (sem_sum < -17'sd32768) begin
			sem_sat = -16'sd32768;
		end else begin
			sem_sat = sem_sum[pts_pkg::SEMV_W-1:0];
		end
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pts_pkg::ST_IDLE: begin
				if (start) begin
					case (ev_in.kind)
						pts_pkg::KIND_TICK: st_d = pts_pkg::ST_TICK;
						pts_pkg::KIND_SUSPEND,
						pts_pkg::KIND_SLEEP: st_d = pts_pkg::ST_PICK;
						pts_pkg::KIND_WAIT,
						pts_pkg::KIND_SIGNAL,
						pts_pkg::KIND_INIT: begin
							st_d = in_sem_ok ? pts_pkg::ST_SEM : pts_pkg::ST_DONE;
						end
						default: st_d = pts_pkg::ST_DONE;
					endcase
				end
			end
			pts_pkg::ST_TICK: begin
				if (last_step) st_d = pts_pkg::ST_DONE;
			end
			pts_pkg::ST_SEM: begin
				if (ev_q.kind == pts_pkg::KIND_WAIT && sem_sat[pts_pkg::SEMV_W-1]) begin
					st_d = pts_pkg::ST_PICK;
				end else if (ev_q.kind == pts_pkg::KIND_SIGNAL &&
				             (sem_sat[pts_pkg::SEMV_W-1] || sem_sat == '0)) begin
					st_d = pts_pkg::ST_WAKE;
				end else begin
					st_d = pts_pkg::ST_DONE;
				end
			end
			pts_pkg::ST_WAKE: begin
				if (ent_match || last_step) st_d = pts_pkg::ST_DONE;
			end
			pts_pkg::ST_PICK: begin
				if (last_step) st_d = pts_pkg::ST_DONE;
			end
			pts_pkg::ST_DONE: begin
				if (res_ready) st_d = pts_pkg::ST_IDLE;
			end
			default: st_d = pts_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		idle      = 1'b0;
		res_valid = 1'b0;
		unique case (st_q)
			pts_pkg::ST_IDLE: idle      = 1'b1;
			pts_pkg::ST_DONE: res_valid = 1'b1;
			default: begin
				idle      = 1'b0;
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= pts_pkg::ST_IDLE;
			cur_q  <= '0;
			prio_q <= '0;
			for (int i = 0; i < TW; i++) begin
				sleep_q[i] <= '0;
				mark_q[i]  <= '0;
			end
			for (int i = 0; i < pts_pkg::SEMAPHORES; i++) begin
				sem_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (cfg_we) prio_q <= cfg_wdata;
			case (st_q)
				pts_pkg::ST_IDLE: begin
					if (start && ev_in.kind == pts_pkg::KIND_SLEEP) begin
						sleep_q[cur_q] <= ev_in.sleep_time;
					end
				end
				pts_pkg::ST_TICK: begin
					if (ent_sleep != '0) sleep_q[t_q] <= ent_sleep - 1'b1;
				end
				pts_pkg::ST_SEM: begin
					if (ev_q.kind == pts_pkg::KIND_INIT) begin
						sem_q[sidx] <= ev_q.init_value;
					end else begin
						sem_q[sidx] <= sem_sat;
						if (ev_q.kind == pts_pkg::KIND_WAIT && sem_sat[pts_pkg::SEMV_W-1]) begin
							mark_q[cur_q] <= sem_mark;
						end
					end
				end
				pts_pkg::ST_WAKE: begin
					if (ent_match) mark_q[t_q] <= '0;
				end
				pts_pkg::ST_PICK: begin
					if (last_step) begin
						if (ent_ready) begin
							cur_q <= t_q;
						end else if (found_q) begin
							cur_q <= pick_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		case (st_q)
			pts_pkg::ST_IDLE: begin
				if (start) begin
					ev_q      <= ev_in;
					old_q     <= cur_q;
					t_q       <= cur_next;
					cnt_q     <= '0;
					best_q    <= pts_pkg::LOWEST_PRIO;
					found_q   <= 1'b0;
					pick_q    <= cur_q;
					none_q    <= 1'b0;
					blocked_q <= 1'b0;
					woke_q    <= 1'b0;
					woken_q   <= '0;
					sval_q    <= '0;
				end
			end
			pts_pkg::ST_TICK: begin
				t_q   <= t_next;
				cnt_q <= cnt_q + 1'b1;
			end
			pts_pkg::ST_SEM: begin
				if (ev_q.kind == pts_pkg::KIND_INIT) begin
					sval_q <= ev_q.init_value;
				end else begin
					sval_q <= sem_sat;
					if (ev_q.kind == pts_pkg::KIND_WAIT && sem_sat[pts_pkg::SEMV_W-1]) begin
						blocked_q <= 1'b1;
					end
				end
			end
			pts_pkg::ST_WAKE: begin
				t_q   <= t_next;
				cnt_q <= cnt_q + 1'b1;
				if (ent_match) begin
					woke_q  <= 1'b1;
					woken_q <= t_q;
				end
			end
			pts_pkg::ST_PICK: begin
				t_q   <= t_next;
				cnt_q <= cnt_q + 1'b1;
				if (ent_ready) begin
					best_q  <= ent_prio;
					pick_q  <= t_q;
					found_q <= 1'b1;
				end
				if (last_step) none_q <= !(ent_ready || found_q);
			end
			default: begin
			end
		endcase
	end

	assign res.running_thread = 3'(cur_q);
	assign res.switched       = (cur_q != old_q);
	assign res.none_ready     = none_q;
	assign res.caller_blocked = blocked_q;
	assign res.woke_valid     = woke_q;
	assign res.woken_thread   = 3'(woken_q);
	assign res.sem_value      = sval_q;

endmodule

/* sv/priority_thread_scheduler_top.sv */
// Top level of the priority thread scheduler: stream ports and the result register.
`timescale 1ns / 1ps

// Event-driven thread scheduler for a ring of eight threads and eight counting semaphores.
// Each event item on the input stream yields exactly one result item. Events are handled one
// at a time, and s_axis_tready is low while an event is in work. A suspend, sleep, blocking
// wait or tick walks all eight thread entries, and a signal that searches for a waiter walks
// them until it finds one or has seen all eight; a kind six or seven and any other event need
// no walk. The walks share one evaluation unit that looks at one thread entry per cycle. The
// result register lets the next event be accepted while a result is still waiting on the
// output. Priorities are written through cfg_we and cfg_wdata; the user must write them only
// while no event is in work, as the block itself does not enforce this.
module priority_thread_scheduler_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pts_pkg::PRIO_BITS-1:0]     cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// sem_id[2:0], sleep_time[34:3], init_value[50:35], zero fill above
	input  logic [pts_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// kind[2:0]
	input  logic [pts_pkg::KIND_W-1:0]        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// running_thread[2:0], switched[3], none_ready[4], caller_blocked[5], woke_valid[6],
	// woken_thread[9:7], sem_value[25:10], zero fill above
	output logic [pts_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	pts_pkg::evt_t ev_in;
	pts_pkg::res_t res;
	logic          core_idle, res_valid, res_ready, start;
	logic          out_valid_q;
	logic [pts_pkg::OUT_DATA_W-1:0] out_data_q;

	assign ev_in.kind       = s_axis_tuser;
	assign ev_in.sem_id     = s_axis_tdata[2:0];
	assign ev_in.sleep_time = s_axis_tdata[34:3];
	assign ev_in.init_value = s_axis_tdata[50:35];

	assign s_axis_tready = core_idle;
	assign start         = s_axis_tvalid && core_idle;
	assign res_ready     = !out_valid_q || m_axis_tready;

	pts_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.ev_in     (ev_in),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= {6'b0, res.sem_value, res.woken_thread, res.woke_valid,
			               res.caller_blocked, res.none_ready, res.switched,
			               res.running_thread};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
